// ===== rtl/dag_shortest_path_macros.svh =====
// Assertion helpers for the shortest path block.
`ifndef DAG_SHORTEST_PATH_MACROS_SVH
`define DAG_SHORTEST_PATH_MACROS_SVH

// A condition implies a consequence in the same cycle.
`define DSP_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// A condition implies a consequence in the next cycle.
`define DSP_ASSERT_NXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dsp_pkg.sv =====
`default_nettype none
package dsp_pkg;
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;
    localparam int VB = $clog2(MAX_VERTICES);
    localparam int EB = $clog2(MAX_EDGES);
    localparam int CB = EB + 1;

    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_SOLVE = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    localparam logic [0:0] CFG_VCOUNT = 1'b0;
    localparam logic [0:0] CFG_SOURCE = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         edge_from;
        logic [5:0]         edge_to;
        logic signed [15:0] edge_weight;
    } t_req;

    typedef struct packed {
        logic [5:0]         vertex_index;
        logic signed [31:0] path_length;
        logic               unreachable;
        logic               edges_dropped;
        logic               last_result;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT,     // pick next unvisited root
        S_SCAN_RD,  // issue edge read for top of stack
        S_SCAN,     // examine edge
        S_POP,      // reload the frame below the popped one
        S_RLX_V,    // pick next vertex in topo order
        S_RLX_T,
        S_RLX_D,
        S_RLX_RD,
        S_RLX,
        S_RLX_CMP,
        S_OUT
    } t_state;

    // edge-store request from the sequencer
    typedef struct packed {
        logic          rd;
        logic [EB-1:0] addr;
    } t_erd;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) sat_add = s[32] ? INT_MIN : INT_MAX;
        else sat_add = s[31:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/dsp_edge_store.sv =====
`default_nettype none
module dsp_edge_store (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [dsp_pkg::EB-1:0] i_waddr,
    input  wire logic [5:0]            i_wtail,
    input  wire logic [5:0]            i_whead,
    input  wire logic [dsp_pkg::WEIGHT_BITS-1:0] i_wweight,
    input  wire dsp_pkg::t_erd         i_rd,
    output logic [5:0]                 o_tail,
    output logic [5:0]                 o_head,
    output logic [dsp_pkg::WEIGHT_BITS-1:0] o_weight
);
    import dsp_pkg::*;
    logic [12+WEIGHT_BITS-1:0] r_mem [MAX_EDGES];
    logic [12+WEIGHT_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wtail, i_whead, i_wweight};
        end
        if (i_rd.rd) begin
            r_q <= r_mem[i_rd.addr];
        end
    end

    assign o_tail   = r_q[12+WEIGHT_BITS-1 -: 6];
    assign o_head   = r_q[WEIGHT_BITS+5 -: 6];
    assign o_weight = r_q[WEIGHT_BITS-1:0];
endmodule
`default_nettype wire

// ===== rtl/dsp_seq.sv =====
`default_nettype none
`include "dag_shortest_path_macros.svh"
module dsp_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_go,
    input  wire logic [6:0]         i_n,
    input  wire logic [5:0]         i_src,
    input  wire logic [dsp_pkg::CB-1:0] i_edges,
    input  wire logic               i_ovf,
    output dsp_pkg::t_erd           o_rd,
    input  wire logic [5:0]         i_tail,
    input  wire logic [5:0]         i_head,
    input  wire logic [dsp_pkg::WEIGHT_BITS-1:0] i_weight,
    output logic                    o_busy,
    output logic                    o_valid,
    output dsp_pkg::t_res           o_res
);
    import dsp_pkg::*;

    t_state r_state, n_state;
    logic [MAX_VERTICES-1:0] r_visit, n_visit, r_reach, n_reach;
    logic [VB+CB-1:0] r_stk  [MAX_VERTICES];   // frames below the top: {vertex, next edge}
    logic [VB-1:0]    r_topo [MAX_VERTICES];
    logic [31:0]      r_dist [MAX_VERTICES];
    logic [VB+CB-1:0] r_stk_q;
    logic [VB-1:0]    r_topo_q;
    logic [31:0]      r_dist_q;
    logic [VB:0]   r_sp, n_sp;       // stack depth, top frame lives in r_v / r_e
    logic [VB:0]   r_done, n_done;   // finished count
    logic [VB:0]   r_root, n_root;   // also relax index / output index
    logic [CB-1:0] r_e, n_e;
    logic [VB-1:0] r_v, n_v;
    logic [31:0]   r_dv, n_dv;       // distance of the vertex being relaxed

    logic [31:0]   cand, w_ext;
    logic          edge_ok, hit;
    logic          push, pop;
    logic          stk_rd, topo_rd, dist_rd, dist_init;
    logic [VB-1:0] stk_raddr, dist_raddr;
    logic [VB:0]   n_lim;

    assign n_lim   = i_n[VB:0];
    assign w_ext   = {{(32-WEIGHT_BITS){i_weight[WEIGHT_BITS-1]}}, i_weight};
    assign cand    = sat_add(r_dv, w_ext);
    assign edge_ok = (i_tail == r_v) && ({1'b0, i_head} < n_lim);

    // next state and scalar regs
    always_comb begin
        n_state = r_state;
        n_visit = r_visit;
        n_reach = r_reach;
        n_sp = r_sp; n_done = r_done; n_root = r_root; n_e = r_e; n_v = r_v; n_dv = r_dv;
        push = 1'b0; pop = 1'b0; hit = 1'b0; dist_init = 1'b0;
        stk_rd = 1'b0; topo_rd = 1'b0; dist_rd = 1'b0;
        stk_raddr = '0; dist_raddr = '0;
        o_rd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_visit = '0; n_sp = '0; n_done = '0; n_root = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_root == n_lim) begin
                    n_reach = '0;
                    if ({1'b0, i_src} < n_lim) begin
                        n_reach[i_src] = 1'b1;
                        dist_init = 1'b1;
                    end
                    n_root = r_done;
                    n_state = S_RLX_V;
                end else begin
                    n_root = r_root + 1'b1;
                    if (!r_visit[r_root[VB-1:0]]) begin
                        n_visit[r_root[VB-1:0]] = 1'b1;
                        n_v = r_root[VB-1:0];
                        n_e = '0;
                        n_sp = (VB+1)'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_e >= i_edges) begin
                    pop = 1'b1;
                    n_sp = r_sp - 1'b1;
                    if (r_done != MAX_VERTICES[VB:0]) n_done = r_done + 1'b1;
                    if (r_sp == (VB+1)'(1)) begin
                        n_state = S_ROOT;
                    end else begin
                        stk_rd = 1'b1;
                        stk_raddr = r_sp[VB-1:0] - VB'(2);
                        n_state = S_POP;
                    end
                end else begin
                    o_rd.rd = 1'b1;
                    o_rd.addr = r_e[EB-1:0];
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_e = r_e + 1'b1;
                n_state = S_SCAN_RD;
                if (edge_ok && !r_visit[i_head] && r_sp != MAX_VERTICES[VB:0]) begin
                    n_visit[i_head] = 1'b1;
                    push = 1'b1;
                    n_sp = r_sp + 1'b1;
                    n_v = i_head;
                    n_e = '0;
                end
            end
            S_POP: begin
                {n_v, n_e} = r_stk_q;
                n_state = S_SCAN_RD;
            end
            S_RLX_V: begin
                if (r_root == '0) begin
                    // prefetch vertex 0 for the first result
                    dist_rd = 1'b1;
                    n_state = S_OUT;
                end else begin
                    topo_rd = 1'b1;
                    n_root = r_root - 1'b1;
                    n_state = S_RLX_T;
                end
            end
            S_RLX_T: begin
                n_v = r_topo_q;
                n_e = '0;
                n_state = S_RLX_V;
                if (r_reach[r_topo_q]) begin
                    dist_rd = 1'b1;
                    dist_raddr = r_topo_q;
                    n_state = S_RLX_D;
                end
            end
            S_RLX_D: begin
                n_dv = r_dist_q;
                n_state = S_RLX_RD;
            end
            S_RLX_RD: begin
                if (r_e >= i_edges) begin
                    n_state = S_RLX_V;
                end else begin
                    o_rd.rd = 1'b1;
                    o_rd.addr = r_e[EB-1:0];
                    n_state = S_RLX;
                end
            end
            S_RLX: begin
                if (edge_ok) begin
                    dist_rd = 1'b1;
                    dist_raddr = i_head;
                    n_state = S_RLX_CMP;
                end else begin
                    n_e = r_e + 1'b1;
                    n_state = S_RLX_RD;
                end
            end
            S_RLX_CMP: begin
                n_e = r_e + 1'b1;
                n_state = S_RLX_RD;
                if (!r_reach[i_head] || $signed(cand) < $signed(r_dist_q)) begin
                    hit = 1'b1;
                    n_reach[i_head] = 1'b1;
                    // self loop: later edges see the new distance
                    if (i_head == r_v) n_dv = cand;
                end
            end
            S_OUT: begin
                n_root = r_root + 1'b1;
                dist_rd = 1'b1;
                dist_raddr = r_root[VB-1:0] + 1'b1;
                if (r_root + 1'b1 == n_lim) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_valid = (r_state == S_OUT);
        o_res.vertex_index  = r_root[VB-1:0];
        o_res.unreachable   = !r_reach[r_root[VB-1:0]];
        o_res.path_length   = r_reach[r_root[VB-1:0]] ? r_dist_q : '0;
        o_res.edges_dropped = i_ovf;
        o_res.last_result   = (r_root + 1'b1 == n_lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_visit <= '0; r_reach <= '0;
            r_sp <= '0; r_done <= '0; r_root <= '0; r_e <= '0; r_v <= '0; r_dv <= '0;
        end else begin
            r_state <= n_state;
            r_visit <= n_visit; r_reach <= n_reach;
            r_sp <= n_sp; r_done <= n_done; r_root <= n_root; r_e <= n_e; r_v <= n_v;
            r_dv <= n_dv;
        end
    end

    // scratch storage, one registered read per array
    always_ff @(posedge i_clk) begin
        if (push) r_stk[r_sp[VB-1:0] - 1'b1] <= {r_v, r_e + 1'b1};
        if (stk_rd) r_stk_q <= r_stk[stk_raddr];
        if (pop && r_done != MAX_VERTICES[VB:0]) r_topo[r_done[VB-1:0]] <= r_v;
        if (topo_rd) r_topo_q <= r_topo[r_root[VB-1:0] - 1'b1];
        if (dist_init) r_dist[i_src] <= '0;
        if (hit) r_dist[i_head] <= cand;
        if (dist_rd) r_dist_q <= r_dist[dist_raddr];
    end

    `DSP_ASSERT_IMP(a_out_busy, i_clk, i_rst_n, o_valid, o_busy, "result outside solve")
    `DSP_ASSERT_IMP(a_sp_max, i_clk, i_rst_n, 1'b1, r_sp <= MAX_VERTICES[VB:0], "stack overrun")
    `DSP_ASSERT_NXT(a_last_idle, i_clk, i_rst_n, o_valid && o_res.last_result, !o_busy, "last not final")
endmodule
`default_nettype wire

// ===== rtl/dag_shortest_path.sv =====
// Shortest paths in a weighted DAG. Request func 0 adds an edge (256-entry
// store, further edges dropped and flagged), 2 clears the store, 1 solves: a
// depth-first topological sort with an explicit stack and then relaxation in
// reverse finishing order, both scanning the edge store through its single
// read port, plus a distance lookup per edge leaving a reached vertex. busy
// stays high through a solve, which ends with its results. Results come one
// per cycle, vertex 0 first, on o_valid with no back-pressure; the receiver
// must take them. busy is low when the next request can be started; add and
// clear never raise it.
`default_nettype none
module dag_shortest_path (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dsp_pkg::t_req i_req,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [6:0]    i_cfg_data,
    output logic               o_valid,
    output dsp_pkg::t_res      o_res
);
    import dsp_pkg::*;

    logic [6:0] r_vcount;
    logic [5:0] r_src;
    logic [CB-1:0] r_edges;
    logic r_ovf;
    logic [6:0] n_clamp;
    logic accept, we, go;
    t_erd rd;
    logic [5:0] tail, head;
    logic [WEIGHT_BITS-1:0] weight;
    logic seq_busy;

    assign busy   = seq_busy;
    assign accept = start && !seq_busy;
    assign we     = accept && (i_req.func == FN_ADD) && (r_edges != MAX_EDGES[CB-1:0]);
    assign go     = accept && (i_req.func == FN_SOLVE);
    assign n_clamp = (r_vcount == '0) ? 7'd1 :
                     (r_vcount > MAX_VERTICES[6:0]) ? MAX_VERTICES[6:0] : r_vcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 7'd64; r_src <= '0; r_edges <= '0; r_ovf <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_VCOUNT) r_vcount <= i_cfg_data;
                else r_src <= i_cfg_data[5:0];
            end
            if (accept && i_req.func == FN_ADD) begin
                if (we) r_edges <= r_edges + 1'b1;
                else r_ovf <= 1'b1;
            end
            if (accept && i_req.func == FN_CLEAR) begin
                r_edges <= '0; r_ovf <= 1'b0;
            end
        end
    end

    dsp_edge_store u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_edges[EB-1:0]),
        .i_wtail(i_req.edge_from), .i_whead(i_req.edge_to),
        .i_wweight(i_req.edge_weight[WEIGHT_BITS-1:0]),
        .i_rd(rd), .o_tail(tail), .o_head(head), .o_weight(weight)
    );

    dsp_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_n(n_clamp), .i_src(r_src),
        .i_edges(r_edges), .i_ovf(r_ovf), .o_rd(rd), .i_tail(tail), .i_head(head),
        .i_weight(weight), .o_busy(seq_busy), .o_valid(o_valid), .o_res(o_res)
    );
endmodule
`default_nettype wire
